/* rtl/fdp_pkg.sv */
// Package for the finite-difference predictor: widths, window size,
// configuration register indexes and the shared stage-to-stage types.
// No dependencies.
package fdp_pkg;

  localparam int unsigned WINDOW   = 5;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned PredW    = 24;
  localparam int unsigned IdxW     = (WINDOW > 2) ? $clog2(WINDOW) : 1;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Difference-table growth: one bit per order plus sign margin.
  localparam int unsigned SumW = SampleW + WINDOW + 1;
  localparam int unsigned AccW = (SumW > PredW) ? SumW : PredW + 1;

  localparam logic [TimeW-1:0] MeasPeriodRst = TimeW'(10);
  localparam logic [IdxW-1:0]  FillRst       = IdxW'(WINDOW - 1);
  localparam logic [IdxW-1:0]  LastPos       = IdxW'(WINDOW - 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INPUT_MODE  = 2'd0,
    CFG_MEAS_PERIOD = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    MODE_ROW   = 1'b0,
    MODE_TIMED = 1'b1
  } input_mode_e;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef sample_t [WINDOW-1:0] window_t;

  // Window snapshot handed from the update stage to the prediction stage.
  typedef struct packed {
    logic    valid;
    window_t win;
  } snap_t;

endpackage

/* rtl/fdp_if.sv */
// Stream interfaces of the finite-difference predictor: sample beats in,
// prediction beats out. Depends on fdp_pkg.
interface fdp_in_if;
  import fdp_pkg::*;
  logic                valid;
  logic                ready;
  logic signed [SampleW-1:0] sample;
  logic [TimeW-1:0]    time_now;

  modport source (output valid, output sample, output time_now, input ready);
  modport sink   (input valid, input sample, input time_now, output ready);
endinterface

interface fdp_out_if;
  import fdp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [PredW-1:0]  prediction;

  modport source (output valid, output prediction, input ready);
  modport sink   (input valid, input prediction, output ready);
endinterface

/* rtl/fdp_window.sv */
// Update stage: configuration registers, window registers, position
// counters and timed-mode schedule; emits a window snapshot per prediction.
// Depends on fdp_pkg and fdp_if.
module fdp_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fdp_in_if.sink                        in_if,
  input  logic                          cfg_we_i,
  input  logic [fdp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fdp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          snap_take_i,
  output fdp_pkg::snap_t                snap_o
);
  import fdp_pkg::*;

  input_mode_e       mode_q;
  logic [TimeW-1:0]  period_q;
  window_t           win_q, win_d, wr_win;
  logic [IdxW-1:0]   fill_q, fill_d;
  logic [IdxW-1:0]   col_q, col_d;
  logic [TimeW-1:0]  start_q, start_d;
  logic              armed_q, armed_d;
  logic              snap_valid_q;
  window_t           snap_win_q;
  logic              accept;
  logic              not_after;
  logic              elapsed;
  logic              write_en;
  logic [IdxW-1:0]   wr_pos;
  logic              fire;
  logic              shift;

  assign in_if.ready = !snap_valid_q || snap_take_i;
  assign accept      = in_if.valid && in_if.ready;
  assign not_after   = (in_if.time_now <= start_q);
  assign elapsed     = ((in_if.time_now - start_q) >= period_q);

  // Mode and schedule decisions.
  always_comb begin
    fill_d   = fill_q;
    col_d    = col_q;
    start_d  = start_q;
    armed_d  = armed_q;
    write_en = 1'b0;
    wr_pos   = col_q;
    fire     = 1'b0;
    shift    = 1'b0;
    if (accept) begin
      if (mode_q == MODE_ROW) begin
        write_en = 1'b1;
        wr_pos   = col_q;
        if (col_q == LastPos) begin
          col_d = '0;
          fire  = 1'b1;
        end else begin
          col_d = col_q + IdxW'(1);
        end
      end else if (not_after) begin
        start_d = in_if.time_now;
        armed_d = 1'b1;
      end else if (elapsed) begin
        if (!armed_q) begin
          start_d = in_if.time_now;
          armed_d = 1'b1;
        end else begin
          armed_d  = 1'b0;
          write_en = 1'b1;
          wr_pos   = fill_q;
          if (fill_q != '0) begin
            fill_d = fill_q - IdxW'(1);
          end else begin
            fire  = 1'b1;
            shift = 1'b1;
          end
        end
      end
    end
  end

  // Window after the write, then after the optional shift up.
  always_comb begin
    wr_win = win_q;
    if (write_en) begin
      wr_win[wr_pos] = in_if.sample;
    end
    win_d = wr_win;
    if (shift) begin
      for (int j = 1; j < WINDOW; j++) begin
        win_d[j] = wr_win[j-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_ROW;
      period_q <= MeasPeriodRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INPUT_MODE:  mode_q   <= input_mode_e'(cfg_wdata_i[0]);
        CFG_MEAS_PERIOD: period_q <= cfg_wdata_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= FillRst;
      col_q        <= '0;
      start_q      <= '0;
      armed_q      <= 1'b0;
      snap_valid_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      col_q   <= col_d;
      start_q <= start_d;
      armed_q <= armed_d;
      if (fire) begin
        snap_valid_q <= 1'b1;
      end else if (snap_take_i) begin
        snap_valid_q <= 1'b0;
      end
    end
  end

  // Payload: no reset.
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (fire) begin
      snap_win_q <= wr_win;
    end
  end

  assign snap_o = {snap_valid_q, snap_win_q};

endmodule

/* rtl/fdp_predict.sv */
// Prediction stage: difference table over the snapshot, saturation and
// the output register. Depends on fdp_pkg and fdp_if.
module fdp_predict (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fdp_pkg::snap_t  snap_i,
  output logic            snap_take_o,
  fdp_out_if.source       out_if
);
  import fdp_pkg::*;

  localparam logic signed [AccW-1:0] PredMaxA = AccW'((2 ** (PredW - 1)) - 1);
  localparam logic signed [AccW-1:0] PredMinA = -PredMaxA - AccW'(1);

  logic signed [AccW-1:0]  diff [WINDOW];
  logic signed [AccW-1:0]  acc;
  logic signed [PredW-1:0] pred_sat;
  logic                    out_valid_q;
  logic signed [PredW-1:0] pred_q;

  // Leading element of each difference order, subtracted from the first sample.
  always_comb begin
    for (int j = 0; j < WINDOW; j++) begin
      diff[j] = AccW'($signed(snap_i.win[j]));
    end
    acc = diff[0];
    for (int m = 1; m < WINDOW; m++) begin
      for (int j = 0; j < WINDOW - m; j++) begin
        diff[j] = diff[j+1] - diff[j];
      end
      acc = acc - diff[0];
    end
    if (acc > PredMaxA) begin
      pred_sat = PredW'(PredMaxA);
    end else if (acc < PredMinA) begin
      pred_sat = PredW'(PredMinA);
    end else begin
      pred_sat = PredW'(acc);
    end
  end

  assign snap_take_o = !out_valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (snap_take_o) begin
      out_valid_q <= snap_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_take_o && snap_i.valid) begin
      pred_q <= pred_sat;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.prediction = pred_q;

endmodule

/* rtl/finite_difference_predictor.sv */
// Top level of the finite-difference predictor: update stage feeding the
// prediction stage. Depends on fdp_pkg, fdp_if, fdp_window, fdp_predict.
//
//   port          | dir | beat contents            | handshake
//   --------------+-----+--------------------------+--------------------
//   in_if         | in  | sample, time_now         | valid / ready
//   out_if        | out | prediction               | valid / ready
//   cfg_*         | in  | cfg_idx_i, cfg_wdata_i   | cfg_we_i, no stall
//
// One sample beat per cycle while in_if.ready is high. The beat that completes
// the window loads the snapshot register, which hands it on to the output
// register once that is free or being taken; the prediction is offered there.
// Reset clears the counters, schedule and valids; the
// sample window holds no reset value. A stalled output holds the
// prediction and, once the snapshot is also waiting, holds in_if.ready low.
module finite_difference_predictor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fdp_in_if.sink                        in_if,
  fdp_out_if.source                     out_if,
  input  logic                          cfg_we_i,
  input  logic [fdp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fdp_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import fdp_pkg::*;

  snap_t snap;
  logic  snap_take;

  // Window update, schedule and snapshot register.
  fdp_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .snap_take_i (snap_take),
    .snap_o      (snap)
  );

  // Difference table, saturation and output register.
  fdp_predict u_predict (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .snap_i      (snap),
    .snap_take_o (snap_take),
    .out_if      (out_if)
  );

endmodule

/* rtl/fdp_checker.sv */
// Port-level checks for the finite-difference predictor, bound to the
// top level. Depends on finite_difference_predictor.
module fdp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [23:0] out_prediction_i
);

  // Stalled prediction beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_prediction_i))
    else $error("prediction beat dropped or changed under stall");

  // Free output side never blocks the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input blocked while output can advance");

  // A new prediction is preceded by an accepted input beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("prediction without a preceding sample beat");

  // Input is never blocked when the output is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && !$past(out_valid_i) |-> in_ready_i)
    else $error("input blocked with empty pipeline");

endmodule

bind finite_difference_predictor fdp_checker u_fdp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_if.valid),
  .in_ready_i       (in_if.ready),
  .out_valid_i      (out_if.valid),
  .out_ready_i      (out_if.ready),
  .out_prediction_i (out_if.prediction)
);

/* dv/finite_difference_predictor_tb.sv */
// Self-checking testbench for the finite-difference predictor: random sample and
// prediction streams checked against an in-bench window predictor.
// Depends on fdp_pkg, fdp_if and the finite_difference_predictor RTL.
`timescale 1ns / 1ps

module finite_difference_predictor_tb;
  import fdp_pkg::*;

  localparam int     CycleLimit = 600000;
  localparam int     PrintCap   = 60;
  localparam longint PredMax    = (longint'(1) << (PredW - 1)) - 1;
  localparam longint PredMin    = -(longint'(1) << (PredW - 1));

  typedef logic signed [PredW-1:0] pred_t;

  typedef struct {
    sample_t          sample;
    logic [TimeW-1:0] time_now;
  } beat_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  fdp_in_if  in_bus ();
  fdp_out_if out_bus ();

  finite_difference_predictor dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_bus),
    .out_if     (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Bench copy of the block state and its configuration.
  input_mode_e      mode_cfg     = MODE_ROW;
  logic [TimeW-1:0] period_cfg   = MeasPeriodRst;
  sample_t          win_q [WINDOW];
  int               row_col      = 0;
  int               fill_pos     = WINDOW - 1;
  logic [TimeW-1:0] period_start = '0;
  logic             armed        = 1'b0;

  beat_t beat_q [$];        // sample beats waiting to be driven
  pred_t pred_q [$];        // predictions still owed by the block
  beat_t cur_beat;
  pred_t want;
  int    beats_queued = 0;
  int    beats_taken  = 0;
  int    idle_left    = 0;
  int    stall_left   = 0;
  int    err_n        = 0;
  int    cycle_n      = 0;
  logic  steady       = 1'b0; // drop all random idling while set
  logic  hold_rx      = 1'b0; // long receiver hold-off
  logic  holdoff_go   = 1'b0;

  initial begin
    in_bus.valid     = 1'b0;
    in_bus.sample    = '0;
    in_bus.time_now  = '0;
    out_bus.ready    = 1'b0;
    for (int j = 0; j < WINDOW; j++) win_q[j] = '0;
  end

  initial begin : clock_gen
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Extrapolate from the window: first sample minus the leading term of every
  // difference order, then clamp to the 24-bit range.
  function automatic pred_t extrapolate();
    longint diff [WINDOW];
    longint acc;
    for (int j = 0; j < WINDOW; j++) diff[j] = longint'(win_q[j]);
    acc = diff[0];
    for (int m = 1; m < int'(WINDOW); m++) begin
      for (int j = 0; j < int'(WINDOW) - m; j++) diff[j] = diff[j + 1] - diff[j];
      acc -= diff[0];
    end
    if (acc > PredMax) acc = PredMax;
    if (acc < PredMin) acc = PredMin;
    return acc[PredW-1:0];
  endfunction

  // Advance the bench state by one accepted beat and record any prediction.
  task automatic apply_beat(beat_t b);
    longint dt;
    if (mode_cfg == MODE_ROW) begin
      win_q[row_col] = b.sample;
      if (row_col == WINDOW - 1) begin
        row_col = 0;
        pred_q.push_back(extrapolate());
      end else begin
        row_col++;
      end
    end else begin
      // Signed distance from the period start; a step back in time re-arms.
      dt = longint'(b.time_now) - longint'(period_start);
      if (dt <= 0) begin
        period_start = b.time_now;
        armed        = 1'b1;
      end else if (dt >= longint'(period_cfg)) begin
        if (!armed) begin
          period_start = b.time_now;
          armed        = 1'b1;
        end else begin
          armed           = 1'b0;
          win_q[fill_pos] = b.sample;
          if (fill_pos != 0) begin
            fill_pos--;
          end else begin
            // Window full: predict, then shift up and drop the top entry.
            pred_q.push_back(extrapolate());
            for (int j = WINDOW - 2; j >= 0; j--) win_q[j + 1] = win_q[j];
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    err_n++;
    if (err_n <= PrintCap) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Full-range sample with the extremes weighted up.
  function automatic sample_t rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return sample_t'(16'sh7FFF);
    if (r < 10) return sample_t'(16'sh8000);
    return sample_t'($urandom());
  endfunction

  task automatic push_beat(sample_t s, logic [TimeW-1:0] t);
    beat_t b;
    b.sample   = s;
    b.time_now = t;
    beat_q.push_back(b);
    beats_queued++;
  endtask

  task automatic queue_rows(int n);
    for (int k = 0; k < n; k++) push_beat(rand_sample(), $urandom());
  endtask

  // Timed stream: mostly steps of at least one period so that measurements
  // land every second beat, with short steps, steps back and jumps as noise.
  task automatic queue_timed(int n);
    logic [TimeW-1:0] t;
    int               r;
    t = $urandom();
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (period_cfg == '1) begin
        // Only a jump from zero to the top of the range spans the period.
        t = (k % 2 == 0) ? '0 : '1;
        if (r < 8) t = $urandom();
      end else if (r < 70) begin
        t = t + period_cfg + $urandom_range(0, 3);
      end else if (r < 82) begin
        t = t + $urandom_range(0, period_cfg);
      end else if (r < 92) begin
        t = t - $urandom_range(0, 20);
      end else begin
        t = $urandom();
      end
      push_beat(rand_sample(), t);
    end
  endtask

  // Wait until every beat is taken and every prediction is back, then let
  // the pipeline drain beats that produce no prediction.
  task automatic drain();
    while (beats_taken != beats_queued) @(posedge clk_i);
    while (pred_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_INPUT_MODE:  mode_cfg   = input_mode_e'(data[0]);
      CFG_MEAS_PERIOD: period_cfg = data[TimeW-1:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sample driver: take the accepted beat, then hold, idle or launch the next.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : sample_driver
    if (in_bus.valid && in_bus.ready) begin
      apply_beat(cur_beat);
      beats_taken++;
    end
    if (in_bus.valid && !in_bus.ready) begin
      // hold the beat until the block takes it
    end else if (idle_left != 0) begin
      idle_left--;
      in_bus.valid <= 1'b0;
    end else if (beat_q.size() != 0) begin
      cur_beat         = beat_q.pop_front();
      in_bus.valid    <= 1'b1;
      in_bus.sample   <= cur_beat.sample;
      in_bus.time_now <= cur_beat.time_now;
      idle_left        = draw_gap();
    end else begin
      in_bus.valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction monitor: check each accepted beat against the oldest expected
  // prediction, then choose the next ready.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : prediction_monitor
    if (out_bus.valid && out_bus.ready) begin
      if (pred_q.size() == 0) begin
        report_mismatch($sformatf("prediction %0d with none expected",
                                  out_bus.prediction));
      end else begin
        want = pred_q.pop_front();
        if (out_bus.prediction !== want)
          report_mismatch($sformatf("prediction got %0d want %0d",
                                    out_bus.prediction, want));
      end
    end
    if (hold_rx) begin
      out_bus.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      stall_left     = draw_gap();
    end
  end

  // Hold the receiver off long enough for the block to fill and stall its
  // input while the driver keeps offering beats.
  initial begin : receiver_holdoff
    wait (holdoff_go);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (150) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  always @(posedge clk_i) begin : watchdog
    cycle_n <= cycle_n + 1;
    if (cycle_n == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Row mode out of reset: constant window, alternating extremes, mixed.
    for (int k = 0; k < WINDOW; k++) push_beat(sample_t'(16'sh7FFF), '1);
    for (int k = 0; k < WINDOW; k++)
      push_beat((k % 2 == 0) ? sample_t'(16'sh8000) : sample_t'(16'sh7FFF), '0);
    push_beat(sample_t'(0), 32'h5555_5555);
    push_beat(sample_t'(1), 32'hAAAA_AAAA);
    push_beat(sample_t'(-2), 32'h0000_FFFF);
    push_beat(sample_t'(16'sh0100), 32'hFFFF_0000);
    push_beat(sample_t'(16'sh8000), 32'h8000_0001);
    drain();

    // Timed mode on the reset period: step back in time, a step short of
    // the period, arming on an unarmed beat, measuring and a jump to the top.
    write_reg(CFG_INPUT_MODE, CfgDataW'(MODE_TIMED));
    push_beat(sample_t'(16'sh1234), 32'd0);
    push_beat(sample_t'(16'sh7FFF), 32'd5);
    push_beat(sample_t'(16'sh8000), 32'd10);
    push_beat(sample_t'(16'sh0001), 32'd20);
    push_beat(sample_t'(16'shFFFF), 32'd25);
    push_beat(sample_t'(16'sh4000), 32'd30);
    push_beat(sample_t'(16'shC000), 32'd28);
    push_beat(sample_t'(16'sh00FF), 32'd38);
    push_beat(sample_t'(16'sh7F00), 32'hFFFF_FFFF);

    // Random phases; counters carry across mode switches on purpose.
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(CFG_INPUT_MODE, CfgDataW'(MODE_ROW));
          queue_rows(123);
          holdoff_go = 1'b1;
        end
        1: begin
          write_reg(CFG_INPUT_MODE, CfgDataW'(MODE_TIMED));
          write_reg(CFG_MEAS_PERIOD, CfgDataW'(1));
          queue_timed(90);
        end
        2: begin
          write_reg(CFG_MEAS_PERIOD, '0);
          queue_timed(60);
        end
        3: begin
          write_reg(CFG_MEAS_PERIOD, '1);
          queue_timed(40);
        end
        4: begin
          steady <= 1'b1;
          write_reg(CFG_INPUT_MODE, CfgDataW'(MODE_ROW));
          queue_rows(97);
        end
        5: begin
          steady <= 1'b0;
          write_reg(CFG_INPUT_MODE, CfgDataW'(MODE_TIMED));
          write_reg(CFG_MEAS_PERIOD, CfgDataW'($urandom_range(2, 40)));
          queue_timed(150);
        end
        6: begin
          // Indexes past the register list must be ignored.
          for (int i = int'(CFG_MEAS_PERIOD) + 1; i < (1 << CfgIdxW); i++)
            write_reg(CfgIdxW'(i), $urandom());
          write_reg(CFG_INPUT_MODE, CfgDataW'(MODE_ROW));
          queue_rows(61);
        end
        default: begin
          write_reg(CFG_INPUT_MODE, CfgDataW'(MODE_TIMED));
          write_reg(CFG_MEAS_PERIOD, CfgDataW'($urandom_range(3, 500)));
          queue_timed(130);
        end
      endcase
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (err_n == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
